// File: src/jpc_pkg.sv
// ----------------------------------------------------------------------------
// jpc_pkg
// Shared types and constants for the Julia set pixel colour block.
// ----------------------------------------------------------------------------
package jpc_pkg;

    localparam int FRAC_BITS = 28;
    localparam int Z_W       = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;
    localparam int SECTOR    = 43;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam int PIX_W      = 12;

    // |z|^2 escape bound, 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

    localparam logic [CFG_ADDR_W-1:0] CFG_C_REAL      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_C_IMAG      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_OFFSET = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_OFFSET = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_HEIGHT = 3'd7;

    localparam logic signed [30:0] C_REAL_RST      = -31'sd187904819;
    localparam logic signed [30:0] C_IMAG_RST      = 31'sd72517838;
    localparam logic [28:0]        REAL_STEP_RST   = 29'd1258291;
    localparam logic [28:0]        IMAG_STEP_RST   = 29'd1118481;
    localparam logic signed [30:0] OFFSET_RST      = 31'sd0;
    localparam logic [11:0]        HALF_WIDTH_RST  = 12'd320;
    localparam logic [11:0]        HALF_HEIGHT_RST = 12'd240;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_RE,
        S_MAP_IM,
        S_SQ_RR,
        S_SQ_II,
        S_SQ_RI,
        S_UPD,
        S_COLOR
    } t_state;

endpackage

// File: src/jpc_mult.sv
// ----------------------------------------------------------------------------
// jpc_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module jpc_mult (
    input  logic                                i_clk,
    input  logic signed [jpc_pkg::MUL_W-1:0]    i_a,
    input  logic signed [jpc_pkg::MUL_W-1:0]    i_b,
    output logic signed [jpc_pkg::PROD_W-1:0]   o_prod
);

    logic signed [2*jpc_pkg::MUL_W-1:0] w_full;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_prod <= signed'(w_full[jpc_pkg::PROD_W-1:0]);
    end

endmodule

// File: src/jpc_hsv2rgb.sv
// ----------------------------------------------------------------------------
// jpc_hsv2rgb
// Integer HSV to RGB, full saturation; six hue sectors 43 wide, the last 41.
// ----------------------------------------------------------------------------
module jpc_hsv2rgb (
    input  logic [7:0] i_hue,
    input  logic [7:0] i_val,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic [2:0]  w_region;
    logic [7:0]  w_base;
    logic [7:0]  w_rem;
    logic [15:0] w_srem;
    logic [15:0] w_sinv;
    logic [15:0] w_q16;
    logic [15:0] w_t16;
    logic [7:0]  w_q;
    logic [7:0]  w_t;

    always_comb begin
        if (i_hue >= 8'(5 * jpc_pkg::SECTOR)) begin
            w_region = 3'd5;
        end else if (i_hue >= 8'(4 * jpc_pkg::SECTOR)) begin
            w_region = 3'd4;
        end else if (i_hue >= 8'(3 * jpc_pkg::SECTOR)) begin
            w_region = 3'd3;
        end else if (i_hue >= 8'(2 * jpc_pkg::SECTOR)) begin
            w_region = 3'd2;
        end else if (i_hue >= 8'(jpc_pkg::SECTOR)) begin
            w_region = 3'd1;
        end else begin
            w_region = 3'd0;
        end
    end

    assign w_base = 8'(int'(w_region) * jpc_pkg::SECTOR);
    assign w_rem  = 8'((i_hue - w_base) * 8'd6);
    assign w_srem = 16'd255 * {8'd0, w_rem};
    assign w_sinv = 16'd255 * {8'd0, 8'd255 - w_rem};
    assign w_q16  = {8'd0, i_val} * {8'd0, 8'd255 - w_srem[15:8]};
    assign w_t16  = {8'd0, i_val} * {8'd0, 8'd255 - w_sinv[15:8]};
    assign w_q    = w_q16[15:8];
    assign w_t    = w_t16[15:8];

    // p is always zero at full saturation
    always_comb begin
        case (w_region)
            3'd0: begin
                o_red = i_val; o_green = w_t;   o_blue = 8'd0;
            end
            3'd1: begin
                o_red = w_q;   o_green = i_val; o_blue = 8'd0;
            end
            3'd2: begin
                o_red = 8'd0;  o_green = i_val; o_blue = w_t;
            end
            3'd3: begin
                o_red = 8'd0;  o_green = w_q;   o_blue = i_val;
            end
            3'd4: begin
                o_red = w_t;   o_green = 8'd0;  o_blue = i_val;
            end
            default: begin
                o_red = i_val; o_green = 8'd0;  o_blue = w_q;
            end
        endcase
    end

endmodule

// File: src/julia_pixel_color.sv
// ----------------------------------------------------------------------------
// julia_pixel_color
// Escape-time colouring of one Julia set pixel on a shared multiplier.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start, i_pixel_x, i_pixel_y (busy is out)  | in
//  result    | o_valid, o_red, o_green, o_blue,          | out
//            | o_iteration_count                         |
//  config    | i_cfg_we, i_cfg_addr, i_cfg_data          | in
//
//  a transaction maps the pixel and then runs K z*z+c steps
//  (at most MAX_ITERATIONS); each step uses the one 33x33 multiplier three times
//  plus one update state. busy is high from the cycle after start until the
//  result strobe. o_valid marks the result for one cycle; the receiver cannot
//  stall it. reset is synchronous, active low, and restores the config values.
// ----------------------------------------------------------------------------
module julia_pixel_color #(
    parameter int MAX_ITERATIONS = 300,
    parameter int COORD_BITS     = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [jpc_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [jpc_pkg::PIX_W-1:0]           i_pixel_y,
    input  logic                                i_cfg_we,
    input  logic [jpc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [jpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [8:0]                          o_iteration_count
);

    localparam int CNT_W = ($clog2(MAX_ITERATIONS + 1) > 9) ?
                           $clog2(MAX_ITERATIONS + 1) : 9;
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_ITERATIONS);
    localparam logic [jpc_pkg::PIX_W-1:0] PIX_MASK =
        (COORD_BITS >= jpc_pkg::PIX_W) ? '1 : jpc_pkg::PIX_W'((1 << COORD_BITS) - 1);
    localparam logic signed [jpc_pkg::PROD_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [jpc_pkg::PROD_W-1:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [jpc_pkg::Z_W-1:0] sat_q(
        input logic signed [jpc_pkg::PROD_W-1:0] v
    );
        logic signed [jpc_pkg::Z_W-1:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = signed'(v[jpc_pkg::Z_W-1:0]);
        end
        return res;
    endfunction

    // config registers
    logic signed [30:0] r_c_real, r_c_imag, r_real_offset, r_imag_offset;
    logic [28:0]        r_real_step, r_imag_step;
    logic [11:0]        r_half_width, r_half_height;

    jpc_pkg::t_state r_state, n_state;

    logic signed [13:0]                  r_dx, r_dy;
    logic signed [jpc_pkg::Z_W-1:0]      r_zr, r_zi;
    logic signed [jpc_pkg::PROD_W-1:0]   r_rr, r_ii;
    logic [CNT_W-1:0]                    r_n;
    logic                                r_stepped;
    logic                                r_esc;

    logic signed [jpc_pkg::MUL_W-1:0]    w_a, w_b;
    logic signed [jpc_pkg::PROD_W-1:0]   w_prod;
    logic signed [30:0]                  w_map_off;
    logic signed [jpc_pkg::Z_W-1:0]      w_map_z;
    logic signed [jpc_pkg::PROD_W-1:0]   w_nr, w_ni;
    logic [jpc_pkg::PROD_W-1:0]          w_mag;
    logic                                w_escape;
    logic [CNT_W-1:0]                    w_n_inc;
    logic                                w_accept;
    logic [7:0]                          w_red, w_green, w_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real      <= jpc_pkg::C_REAL_RST;
            r_c_imag      <= jpc_pkg::C_IMAG_RST;
            r_real_step   <= jpc_pkg::REAL_STEP_RST;
            r_imag_step   <= jpc_pkg::IMAG_STEP_RST;
            r_real_offset <= jpc_pkg::OFFSET_RST;
            r_imag_offset <= jpc_pkg::OFFSET_RST;
            r_half_width  <= jpc_pkg::HALF_WIDTH_RST;
            r_half_height <= jpc_pkg::HALF_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                jpc_pkg::CFG_C_REAL:      r_c_real      <= signed'(i_cfg_data);
                jpc_pkg::CFG_C_IMAG:      r_c_imag      <= signed'(i_cfg_data);
                jpc_pkg::CFG_REAL_STEP:   r_real_step   <= i_cfg_data[28:0];
                jpc_pkg::CFG_IMAG_STEP:   r_imag_step   <= i_cfg_data[28:0];
                jpc_pkg::CFG_REAL_OFFSET: r_real_offset <= signed'(i_cfg_data);
                jpc_pkg::CFG_IMAG_OFFSET: r_imag_offset <= signed'(i_cfg_data);
                jpc_pkg::CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[11:0];
                jpc_pkg::CFG_HALF_HEIGHT: r_half_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != jpc_pkg::S_IDLE);
    assign w_accept = start && !busy;

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            jpc_pkg::S_MAP_RE: begin
                w_a = signed'({4'd0, r_real_step});
                w_b = jpc_pkg::MUL_W'(r_dx);
            end
            jpc_pkg::S_MAP_IM: begin
                w_a = signed'({4'd0, r_imag_step});
                w_b = jpc_pkg::MUL_W'(r_dy);
            end
            jpc_pkg::S_SQ_RR: begin
                w_a = jpc_pkg::MUL_W'(r_zr);
                w_b = jpc_pkg::MUL_W'(r_zr);
            end
            jpc_pkg::S_SQ_II: begin
                w_a = jpc_pkg::MUL_W'(r_zi);
                w_b = jpc_pkg::MUL_W'(r_zi);
            end
            jpc_pkg::S_SQ_RI: begin
                w_a = jpc_pkg::MUL_W'(r_zr);
                w_b = jpc_pkg::MUL_W'(r_zi);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    jpc_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_map_off = (r_state == jpc_pkg::S_MAP_IM) ? r_real_offset : r_imag_offset;
    assign w_map_z   = sat_q(w_prod + jpc_pkg::PROD_W'(w_map_off));
    assign w_nr      = (r_rr >>> jpc_pkg::FRAC_BITS) - (r_ii >>> jpc_pkg::FRAC_BITS)
                       + jpc_pkg::PROD_W'(r_c_real);
    assign w_ni      = (w_prod >>> (jpc_pkg::FRAC_BITS - 1)) + jpc_pkg::PROD_W'(r_c_imag);
    assign w_mag     = $unsigned(r_rr) + $unsigned(w_prod);
    assign w_escape  = (w_mag > jpc_pkg::ESC_LIMIT);
    assign w_n_inc   = r_n + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            jpc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = jpc_pkg::S_MAP_RE;
                end
            end
            jpc_pkg::S_MAP_RE: n_state = jpc_pkg::S_MAP_IM;
            jpc_pkg::S_MAP_IM: n_state = jpc_pkg::S_SQ_RR;
            jpc_pkg::S_SQ_RR:  n_state = jpc_pkg::S_SQ_II;
            jpc_pkg::S_SQ_II:  n_state = jpc_pkg::S_SQ_RI;
            jpc_pkg::S_SQ_RI: begin
                if (r_stepped && (w_escape || w_n_inc == N_MAX)) begin
                    n_state = jpc_pkg::S_COLOR;
                end else begin
                    n_state = jpc_pkg::S_UPD;
                end
            end
            jpc_pkg::S_UPD:    n_state = jpc_pkg::S_SQ_RR;
            jpc_pkg::S_COLOR:  n_state = jpc_pkg::S_IDLE;
            default:           n_state = jpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jpc_pkg::S_IDLE;
            r_n       <= '0;
            r_stepped <= 1'b0;
            r_esc     <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == jpc_pkg::S_COLOR);
            if (w_accept) begin
                r_n       <= '0;
                r_stepped <= 1'b0;
                r_esc     <= 1'b0;
            end
            if (r_state == jpc_pkg::S_SQ_RI && r_stepped) begin
                if (w_escape) begin
                    r_esc <= 1'b1;
                end else begin
                    r_n <= w_n_inc;
                end
            end
            if (r_state == jpc_pkg::S_UPD) begin
                r_stepped <= 1'b1;
            end
        end
    end

    jpc_hsv2rgb u_hsv2rgb (
        .i_hue   (r_n[7:0]),
        .i_val   (r_esc ? 8'd255 : 8'd0),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dx <= signed'({2'b00, i_pixel_x & PIX_MASK}) - signed'({2'b00, r_half_width});
            r_dy <= signed'({2'b00, i_pixel_y & PIX_MASK}) - signed'({2'b00, r_half_height});
        end
        case (r_state)
            jpc_pkg::S_MAP_IM: r_zr <= w_map_z;
            jpc_pkg::S_SQ_RR: begin
                if (!r_stepped) begin
                    r_zi <= w_map_z;
                end
            end
            jpc_pkg::S_SQ_II:  r_rr <= w_prod;
            jpc_pkg::S_SQ_RI:  r_ii <= w_prod;
            jpc_pkg::S_UPD: begin
                r_zr <= sat_q(w_nr);
                r_zi <= sat_q(w_ni);
            end
            jpc_pkg::S_COLOR: begin
                o_red             <= w_red;
                o_green           <= w_green;
                o_blue            <= w_blue;
                o_iteration_count <= r_n[8:0];
            end
            default: ;
        endcase
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_MAX)
        else $error("iteration count beyond maximum");

    a_bounded_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jpc_pkg::S_COLOR && !r_esc) |-> (r_n == N_MAX))
        else $error("non-escaped point without full count");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

endmodule
